// ----- src/cvx_pkg.sv -----
// shared types and constants for the polygon convexity check unit
// no dependencies

package cvx_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
   localparam int PROD_WIDTH      = 2 * DIFF_WIDTH;
   localparam int CROSS_WIDTH     = PROD_WIDTH + 1;
   localparam int MIN_VERTICES    = 3;
   localparam int NUM_TURNS       = 3;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] vertex_x;
      logic signed [COORD_WIDTH-1:0] vertex_y;
      logic                          last_vertex;
   } req_type;

   typedef struct packed {
      logic convex;
      logic too_few_vertices;
   } rsp_type;

   // edge vectors of one turn: cross = a*d - b*c
   typedef struct packed {
      logic                         valid;
      logic signed [DIFF_WIDTH-1:0] a;
      logic signed [DIFF_WIDTH-1:0] b;
      logic signed [DIFF_WIDTH-1:0] c;
      logic signed [DIFF_WIDTH-1:0] d;
   } turn_type;

   typedef struct packed {
      turn_type [NUM_TURNS-1:0] turns;
      logic                     last;
      logic                     too_few;
   } job_type;

endpackage

// ----- src/cvx_front.sv -----
// front end: takes vertices, tracks the vertex window, forms turn edge vectors
// depends on cvx_pkg

module cvx_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  cvx_pkg::req_type req_item,
   output logic             job_push,
   output cvx_pkg::job_type job
);
   import cvx_pkg::*;

   localparam int COUNT_WIDTH = 2;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE  = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_TWO  = COUNT_WIDTH'(2);
   localparam logic [COUNT_WIDTH-1:0] COUNT_SAT  = COUNT_WIDTH'(MIN_VERTICES);
   localparam logic [COUNT_WIDTH-1:0] COUNT_ZERO = '0;

   logic signed [COORD_WIDTH-1:0] first_x_ff, first_y_ff, first_x_in, first_y_in;
   logic signed [COORD_WIDTH-1:0] second_x_ff, second_y_ff, second_x_in, second_y_in;
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_y_ff, prev_x_in, prev_y_in;
   logic signed [COORD_WIDTH-1:0] cur_x_ff, cur_y_ff, cur_x_in, cur_y_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;

   function automatic turn_type make_turn(
      input logic                          en,
      input logic signed [COORD_WIDTH-1:0] ax,
      input logic signed [COORD_WIDTH-1:0] ay,
      input logic signed [COORD_WIDTH-1:0] bx,
      input logic signed [COORD_WIDTH-1:0] by,
      input logic signed [COORD_WIDTH-1:0] nx,
      input logic signed [COORD_WIDTH-1:0] ny
   );
      turn_type t;
      t.valid = en;
      t.a = DIFF_WIDTH'(bx) - DIFF_WIDTH'(ax);
      t.b = DIFF_WIDTH'(by) - DIFF_WIDTH'(ay);
      t.c = DIFF_WIDTH'(nx) - DIFF_WIDTH'(bx);
      t.d = DIFF_WIDTH'(ny) - DIFF_WIDTH'(by);
      return t;
   endfunction

   logic has_turn;
   logic closes;

   always_comb begin
      has_turn = (count_ff >= COUNT_TWO);
      closes   = req_item.last_vertex && has_turn;

      job.turns[0] = make_turn(has_turn, prev_x_ff, prev_y_ff, cur_x_ff, cur_y_ff,
                               req_item.vertex_x, req_item.vertex_y);
      job.turns[1] = make_turn(closes, cur_x_ff, cur_y_ff,
                               req_item.vertex_x, req_item.vertex_y,
                               first_x_ff, first_y_ff);
      job.turns[2] = make_turn(closes, req_item.vertex_x, req_item.vertex_y,
                               first_x_ff, first_y_ff, second_x_ff, second_y_ff);
      job.last     = req_item.last_vertex;
      job.too_few  = req_item.last_vertex && !has_turn;
      job_push     = accept && (has_turn || req_item.last_vertex);

      first_x_in  = first_x_ff;
      first_y_in  = first_y_ff;
      second_x_in = second_x_ff;
      second_y_in = second_y_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      count_in    = count_ff;
      if (accept) begin
         if (count_ff == COUNT_ZERO) begin
            first_x_in = req_item.vertex_x;
            first_y_in = req_item.vertex_y;
         end
         if (count_ff == COUNT_ONE) begin
            second_x_in = req_item.vertex_x;
            second_y_in = req_item.vertex_y;
         end
         prev_x_in = cur_x_ff;
         prev_y_in = cur_y_ff;
         cur_x_in  = req_item.vertex_x;
         cur_y_in  = req_item.vertex_y;
         if (req_item.last_vertex) begin
            count_in = COUNT_ZERO;
         end else if (count_ff != COUNT_SAT) begin
            count_in = count_ff + COUNT_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_ZERO;
      end else begin
         count_ff <= count_in;
      end
      first_x_ff  <= first_x_in;
      first_y_ff  <= first_y_in;
      second_x_ff <= second_x_in;
      second_y_ff <= second_y_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
   end

endmodule

// ----- src/cvx_queue.sv -----
// short job queue between front end and back end
// depends on cvx_pkg

module cvx_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  cvx_pkg::job_type wr_data,
   output logic             q_full,
   input  logic             rd_en,
   output logic             q_avail,
   output cvx_pkg::job_type rd_data
);
   import cvx_pkg::*;

   localparam logic [QUEUE_PTR_WIDTH:0] FILL_MAX = (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH);
   localparam logic [QUEUE_PTR_WIDTH:0] FILL_ONE = (QUEUE_PTR_WIDTH+1)'(1);
   localparam logic [QUEUE_PTR_WIDTH-1:0] PTR_ONE = QUEUE_PTR_WIDTH'(1);

   job_type                    slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_WIDTH:0]   fill_ff, fill_in;
   logic                       do_wr, do_rd;

   always_comb begin
      q_full    = (fill_ff == FILL_MAX);
      q_avail   = (fill_ff != '0);
      rd_data   = slots_ff[rd_ptr_ff];
      do_wr     = wr_en && !q_full;
      do_rd     = rd_en && q_avail;
      wr_ptr_in = do_wr ? wr_ptr_ff + PTR_ONE : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + PTR_ONE : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + FILL_ONE;
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - FILL_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_wr) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- src/cvx_back.sv -----
// back end: cross products, turn sign tracking and the result register
// depends on cvx_pkg

module cvx_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_avail,
   input  cvx_pkg::job_type job,
   output logic             job_pop,
   output logic             empty,
   input  logic             pop,
   output cvx_pkg::rsp_type rsp_item
);
   import cvx_pkg::*;

   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_last_ff, s1_too_few_ff;
   logic [NUM_TURNS-1:0]         s1_turn_ff;
   logic signed [PROD_WIDTH-1:0] prod_p_ff [NUM_TURNS];
   logic signed [PROD_WIDTH-1:0] prod_q_ff [NUM_TURNS];
   logic                         pos_ff, pos_in, neg_ff, neg_in;
   logic                         res_valid_ff, res_valid_in;
   rsp_type                      res_ff, res_in;

   logic                          pipe_go, s1_fire;
   logic signed [CROSS_WIDTH-1:0] cross_val [NUM_TURNS];
   logic [NUM_TURNS-1:0]          turn_pos, turn_neg;
   logic                          acc_pos, acc_neg;

   always_comb begin
      pipe_go     = !(s1_valid_ff && s1_last_ff && res_valid_ff && !pop);
      job_pop     = job_avail && pipe_go;
      s1_fire     = s1_valid_ff && pipe_go;
      s1_valid_in = pipe_go ? job_avail : s1_valid_ff;

      for (int i = 0; i < NUM_TURNS; i++) begin
         cross_val[i] = CROSS_WIDTH'(prod_p_ff[i]) - CROSS_WIDTH'(prod_q_ff[i]);
         turn_neg[i]  = s1_turn_ff[i] && cross_val[i][CROSS_WIDTH-1];
         turn_pos[i]  = s1_turn_ff[i] && !cross_val[i][CROSS_WIDTH-1] && (cross_val[i] != '0);
      end
      acc_pos = pos_ff || (|turn_pos);
      acc_neg = neg_ff || (|turn_neg);

      pos_in       = pos_ff;
      neg_in       = neg_ff;
      res_valid_in = res_valid_ff && !pop;
      res_in       = res_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            pos_in                  = 1'b0;
            neg_in                  = 1'b0;
            res_valid_in            = 1'b1;
            res_in.too_few_vertices = s1_too_few_ff;
            res_in.convex           = !s1_too_few_ff && !(acc_pos && acc_neg);
         end else begin
            pos_in = acc_pos;
            neg_in = acc_neg;
         end
      end

      empty    = !res_valid_ff;
      rsp_item = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         pos_ff       <= 1'b0;
         neg_ff       <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         pos_ff       <= pos_in;
         neg_ff       <= neg_in;
         res_valid_ff <= res_valid_in;
      end
      res_ff <= res_in;
      if (job_pop) begin
         s1_last_ff    <= job.last;
         s1_too_few_ff <= job.too_few;
         for (int i = 0; i < NUM_TURNS; i++) begin
            s1_turn_ff[i] <= job.turns[i].valid;
            prod_p_ff[i]  <= PROD_WIDTH'(job.turns[i].a) * PROD_WIDTH'(job.turns[i].d);
            prod_q_ff[i]  <= PROD_WIDTH'(job.turns[i].b) * PROD_WIDTH'(job.turns[i].c);
         end
      end
   end

endmodule

// ----- src/polygon_convexity_check_unit.sv -----
// top level of the polygon convexity check unit
// depends on cvx_pkg, cvx_front, cvx_queue, cvx_back
//
// usage:
//   input queue side: drive req_item and raise push; a vertex transfers on a
//   clock edge with push high and full low. last_vertex marks the final
//   vertex of a polygon; the next vertex starts a new polygon.
//   result queue side: while empty is low, rsp_item holds one result per
//   polygon (convex, or too_few_vertices for under three vertices); it
//   transfers on a clock edge with pop high and empty low.
//   throughput: one vertex per cycle while full is low. the front end forms
//   edge vectors for up to three turns per vertex, a four-entry job queue
//   decouples it from the back end, which multiplies in one stage and
//   resolves signs in the next.
//   path: after its last vertex transfers, a result passes through the job
//   queue, the product register and the output register to rsp_item.
//   stall: a result waits in the output register while pop is low; vertices
//   keep transferring until the job queue fills, then full rises.
//   reset: synchronous, active high; clears all polygon state and queues.

module polygon_convexity_check_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  cvx_pkg::req_type req_item,
   output logic             empty,
   input  logic             pop,
   output cvx_pkg::rsp_type rsp_item
);
   import cvx_pkg::*;

   logic    accept;
   logic    job_push, job_pop, job_avail;
   job_type front_job, queue_job;

   assign accept = push && !full;

   cvx_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .job_push (job_push),
      .job      (front_job)
   );

   cvx_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_data (front_job),
      .q_full  (full),
      .rd_en   (job_pop),
      .q_avail (job_avail),
      .rd_data (queue_job)
   );

   cvx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_avail (job_avail),
      .job       (queue_job),
      .job_pop   (job_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item)
   );

endmodule

// ----- sim/cvx_check_sb_pkg.sv -----
// scoreboard for the polygon convexity check unit: predicts one verdict per polygon
// from the accepted vertex stream and compares it with each result transfer
// depends on cvx_pkg
`timescale 1ns / 1ps

package cvx_check_sb_pkg;

   import cvx_pkg::*;

   typedef enum logic [1:0] {
      HEADING_NONE,
      HEADING_LEFT,
      HEADING_RIGHT
   } heading_type;

   class convexity_tracker;

      logic signed [COORD_WIDTH-1:0] head_x, head_y, next_x, next_y;
      logic signed [COORD_WIDTH-1:0] back_x, back_y, tip_x, tip_y;
      int                            seen;
      heading_type                   heading;
      bit                            bent;
      rsp_type                       verdicts_due[$];
      int                            mismatches;

      function new();
         mismatches = 0;
         clear_polygon();
      endfunction

      function void clear_polygon();
         head_x = '0;
         head_y = '0;
         next_x = '0;
         next_y = '0;
         back_x = '0;
         back_y = '0;
         tip_x = '0;
         tip_y = '0;
         seen = 0;
         heading = HEADING_NONE;
         bent = 1'b0;
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction

      function void bend_at(logic signed [COORD_WIDTH-1:0] ax, logic signed [COORD_WIDTH-1:0] ay,
                            logic signed [COORD_WIDTH-1:0] bx, logic signed [COORD_WIDTH-1:0] by,
                            logic signed [COORD_WIDTH-1:0] nx, logic signed [COORD_WIDTH-1:0] ny);
         longint      turn_cross;
         heading_type dir;
         turn_cross = (longint'(bx) - longint'(ax)) * (longint'(ny) - longint'(by))
                    - (longint'(by) - longint'(ay)) * (longint'(nx) - longint'(bx));
         if (turn_cross == 0) return;
         dir = (turn_cross > 0) ? HEADING_LEFT : HEADING_RIGHT;
         if (heading == HEADING_NONE) heading = dir;
         else if (heading != dir) bent = 1'b1;
      endfunction

      function void note_vertex(req_type v);
         rsp_type verdict;
         if (seen == 0) begin
            head_x = v.vertex_x;
            head_y = v.vertex_y;
         end else if (seen == 1) begin
            next_x = v.vertex_x;
            next_y = v.vertex_y;
         end else begin
            bend_at(back_x, back_y, tip_x, tip_y, v.vertex_x, v.vertex_y);
         end
         back_x = tip_x;
         back_y = tip_y;
         tip_x = v.vertex_x;
         tip_y = v.vertex_y;
         if (seen < MIN_VERTICES) seen++;
         if (!v.last_vertex) return;
         if (seen < MIN_VERTICES) begin
            verdict.convex = 1'b0;
            verdict.too_few_vertices = 1'b1;
         end else begin
            bend_at(back_x, back_y, tip_x, tip_y, head_x, head_y);
            bend_at(tip_x, tip_y, head_x, head_y, next_x, next_y);
            verdict.convex = !bent;
            verdict.too_few_vertices = 1'b0;
         end
         verdicts_due.push_back(verdict);
         clear_polygon();
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (verdicts_due.size() == 0) begin
            $display("%0t: result transfer with none expected, actual convex=%0b too_few=%0b",
                     $time, got.convex, got.too_few_vertices);
            mismatches++;
            return;
         end
         want = verdicts_due.pop_front();
         if (got.convex !== want.convex) begin
            $display("%0t: convex mismatch, expected %0b actual %0b",
                     $time, want.convex, got.convex);
            mismatches++;
         end
         if (got.too_few_vertices !== want.too_few_vertices) begin
            $display("%0t: too_few_vertices mismatch, expected %0b actual %0b",
                     $time, want.too_few_vertices, got.too_few_vertices);
            mismatches++;
         end
      endfunction

   endclass

endpackage

// ----- sim/tb_top.sv -----
// testbench top for polygon_convexity_check_unit: directed and random polygons,
// random idling on both queue sides and one long result hold-off
// depends on cvx_pkg and cvx_check_sb_pkg
`timescale 1ns / 1ps

module tb_top;

   import cvx_pkg::*;
   import cvx_check_sb_pkg::*;

   localparam int VERTEX_TARGET = 1100;
   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 90;
   localparam int HOLD_AFTER    = 300;
   localparam int RING_POINTS   = 16;
   localparam int RING_COS[RING_POINTS] = '{100, 92, 71, 38, 0, -38, -71, -92,
                                            -100, -92, -71, -38, 0, 38, 71, 92};

   logic    clock = 1'b0;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_item;
   logic    empty;
   logic    pop;
   rsp_type rsp_item;

   convexity_tracker tracker = new();
   int               vertices_sent = 0;
   int               quiet_cycles = 0;
   bit               idle_on = 1'b1;

   polygon_convexity_check_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (reset !== 1'b1) begin
         if (push && !full) tracker.note_vertex(req_item);
         if (pop && !empty) tracker.check_result(rsp_item);
         if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // result side: random idling plus one long hold-off to fill the block
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      pop = 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (!held && vertices_sent >= HOLD_AFTER) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= idle_on ? ($urandom_range(99) >= 38) : 1'b1;
         end
         @(negedge clock);
      end
   end

   task automatic offer_vertex(input int x, input int y, input logic last);
      while (idle_on && $urandom_range(99) < 38) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_item <= '{vertex_x: x[COORD_WIDTH-1:0], vertex_y: y[COORD_WIDTH-1:0],
                    last_vertex: last};
      do @(posedge clock); while (full);
      vertices_sent++;
      @(negedge clock);
   endtask

   // ordered subset of a ring, scaled and shifted, walked either way
   task automatic offer_convex_polygon();
      int picks[$];
      int want, i, k, j, p, n, scale, ox, oy, start;
      bit forward;
      want = $urandom_range(3, 10);
      for (i = 0; i < RING_POINTS; i++)
         if (int'($urandom_range(RING_POINTS - 1 - i)) < want - picks.size()) picks.push_back(i);
      n = picks.size();
      scale = $urandom_range(1, 300);
      ox = int'($urandom_range(4000)) - 2000;
      oy = int'($urandom_range(4000)) - 2000;
      start = $urandom_range(n - 1);
      forward = $urandom_range(1);
      for (k = 0; k < n; k++) begin
         j = forward ? (start + k) % n : (start - k + n) % n;
         p = picks[j];
         offer_vertex(ox + scale * RING_COS[p], oy + scale * RING_COS[(p + 12) % RING_POINTS],
                      k == n - 1);
      end
   endtask

   task automatic offer_wide_polygon();
      int n, k;
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++) offer_vertex($urandom, $urandom, k == n - 1);
   endtask

   task automatic offer_line_polygon();
      int n, k, bx, by, sx, sy, t;
      n = $urandom_range(2, 8);
      bx = int'($urandom_range(40000)) - 20000;
      by = int'($urandom_range(40000)) - 20000;
      sx = int'($urandom_range(100)) - 50;
      sy = int'($urandom_range(100)) - 50;
      for (k = 0; k < n; k++) begin
         t = $urandom_range(10);
         offer_vertex(bx + t * sx, by + t * sy, k == n - 1);
      end
   endtask

   task automatic offer_tiny_polygon();
      int n, k;
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++)
         offer_vertex(int'($urandom_range(6)) - 3, int'($urandom_range(6)) - 3, k == n - 1);
   endtask

   initial begin
      int pick;
      reset = 1'b1;
      push = 1'b0;
      req_item = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single vertex and two vertices
      offer_vertex(-32768, -32768, 1'b1);
      offer_vertex(32767, 32767, 1'b0);
      offer_vertex(-32768, 0, 1'b1);
      // small counterclockwise triangle
      offer_vertex(0, 0, 1'b0);
      offer_vertex(10, 0, 1'b0);
      offer_vertex(0, 10, 1'b1);
      // clockwise square at the coordinate extremes
      offer_vertex(-32768, 32767, 1'b0);
      offer_vertex(32767, 32767, 1'b0);
      offer_vertex(32767, -32768, 1'b0);
      offer_vertex(-32768, -32768, 1'b1);
      // collinear points
      offer_vertex(1, 1, 1'b0);
      offer_vertex(2, 2, 1'b0);
      offer_vertex(3, 3, 1'b0);
      offer_vertex(3, 3, 1'b1);
      // arrowhead, not convex
      offer_vertex(0, 0, 1'b0);
      offer_vertex(10, 5, 1'b0);
      offer_vertex(20, 0, 1'b0);
      offer_vertex(10, 20, 1'b1);
      // one repeated point
      offer_vertex(5, 5, 1'b0);
      offer_vertex(5, 5, 1'b0);
      offer_vertex(5, 5, 1'b1);

      while (vertices_sent < VERTEX_TARGET) begin
         idle_on = !(vertices_sent >= 600 && vertices_sent < 800);
         pick = $urandom_range(99);
         if (pick < 60) offer_convex_polygon();
         else if (pick < 75) offer_wide_polygon();
         else if (pick < 85) offer_line_polygon();
         else offer_tiny_polygon();
      end
      idle_on = 1'b1;
      push <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
